### rtl/core/ostu_pkg.sv
// Shared types and codes for the object seek transform step unit.
// Used by ostu_norm and object_seek_transform_step_unit; depends on nothing.
`timescale 1ns / 1ps

package ostu_pkg;

  // Q16.16 one
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic [30:0] SPEED_RESET  = 31'h0001_0000;
  localparam logic [30:0] ARRIVE_RESET = 31'h0000_8000;

  // Request kinds
  localparam logic [2:0] REQ_SEEK_GATED = 3'd0;
  localparam logic [2:0] REQ_SEEK       = 3'd1;
  localparam logic [2:0] REQ_LOOK_AT    = 3'd2;
  localparam logic [2:0] REQ_FWD        = 3'd3;
  localparam logic [2:0] REQ_BACK       = 3'd4;
  localparam logic [2:0] REQ_LEFT       = 3'd5;
  localparam logic [2:0] REQ_RIGHT      = 3'd6;
  localparam logic [2:0] REQ_SET_FLAG   = 3'd7;

  // Configuration register indexes
  localparam logic CFG_SPEED  = 1'b0;
  localparam logic CFG_ARRIVE = 1'b1;

  // Vector components handed to the normalizer are wide enough for the
  // cross product of the up axis with a look axis.
  typedef logic signed [48:0] wide_t;
  typedef logic signed [31:0] q_t;
  typedef logic signed [17:0] unit_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic rdy;
    logic done;
  } norm_stat_t;

endpackage

### rtl/core/ostu_norm.sv
// Iterative vector normalizer: prescale, sum of squares, square root and
// per-component division, one step per cycle. Depends on ostu_pkg; borrows
// the multiplier of the top level through mul_req and mul_p.
`timescale 1ns / 1ps

module ostu_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 len_only,
  input  ostu_pkg::wide_t      vec [3],
  input  logic [63:0]          mul_p,
  output ostu_pkg::mul_req_t   mul_req,
  output ostu_pkg::norm_stat_t stat,
  output ostu_pkg::unit_t      unit [3],
  output logic [31:0]          len,
  output logic [4:0]           shift
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_HALVE = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_DONE  = 3'd5;

  logic [2:0]      st_r, st_nxt;
  logic [47:0]     mag_r [3];
  logic [2:0]      neg_r;
  logic            lonly_r;
  logic [4:0]      k_r;
  logic [4:0]      cnt_r;
  logic [1:0]      idx_r;
  logic [63:0]     acc_r, root_r, bit_r;
  logic [32:0]     rem_r;
  logic [16:0]     q_r;
  ostu_pkg::unit_t unit_r [3];
  logic [31:0]     len_r;

  logic            too_big;
  logic [1:0]      sel_idx;
  logic [47:0]     mag_sel, mag_nx;
  logic [63:0]     trial, root_nxt;
  logic            take;
  logic            div_take;
  logic [32:0]     rem_sub, rem_nxt;
  logic [16:0]     q_nxt;

  function automatic logic over31(input logic [47:0] m);
    return (|m[47:32]) || (m[31] && (|m[30:0]));
  endfunction

  function automatic logic [47:0] magn(input ostu_pkg::wide_t v);
    logic [48:0] a;
    a = v[48] ? 49'(-v) : 49'(v);
    return a[47:0];
  endfunction

  assign too_big = over31(mag_r[0]) || over31(mag_r[1]) || over31(mag_r[2]);
  assign sel_idx = (st_r == N_SQ) ? cnt_r[1:0] : idx_r;

  always_comb begin
    case (sel_idx)
      2'd0:    mag_sel = mag_r[0];
      2'd1:    mag_sel = mag_r[1];
      default: mag_sel = mag_r[2];
    endcase
    case (idx_r)
      2'd0:    mag_nx = mag_r[1];
      default: mag_nx = mag_r[2];
    endcase
  end

  // One bit pair of the root per cycle.
  assign trial    = root_r + bit_r;
  assign take     = acc_r >= trial;
  assign root_nxt = take ? ((root_r >> 1) + bit_r) : (root_r >> 1);

  // Restoring division; the magnitude never exceeds the length, so the
  // quotient has seventeen bits.
  assign div_take = rem_r >= {1'b0, len_r};
  assign rem_sub  = rem_r - {1'b0, len_r};
  assign rem_nxt  = div_take ? {rem_sub[31:0], 1'b0} : {rem_r[31:0], 1'b0};
  assign q_nxt    = {q_r[15:0], div_take};

  assign mul_req.a = mag_sel[31:0];
  assign mul_req.b = mag_sel[31:0];
  assign stat.rdy  = (st_r == N_IDLE) || (st_r == N_DONE);
  assign stat.done = (st_r == N_DONE);
  assign unit      = unit_r;
  assign len       = len_r;
  assign shift     = k_r;

  always_comb begin
    case (st_r)
      N_IDLE, N_DONE: st_nxt = start ? N_HALVE : N_IDLE;
      N_HALVE:        st_nxt = too_big ? N_HALVE : N_SQ;
      N_SQ:           st_nxt = (cnt_r == 5'd3) ? N_SQRT : N_SQ;
      N_SQRT: begin
        if (bit_r[0]) begin
          st_nxt = (lonly_r || (root_nxt == 64'd0)) ? N_DONE : N_DIV;
        end else begin
          st_nxt = N_SQRT;
        end
      end
      N_DIV:   st_nxt = ((cnt_r == 5'd16) && (idx_r == 2'd2)) ? N_DONE : N_DIV;
      default: st_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      N_IDLE, N_DONE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= magn(vec[i]);
            neg_r[i] <= vec[i][48];
          end
          k_r     <= 5'd0;
          lonly_r <= len_only;
          cnt_r   <= 5'd0;
          acc_r   <= 64'd0;
        end
      end
      N_HALVE: begin
        if (too_big) begin
          for (int i = 0; i < 3; i++) begin
            mag_r[i] <= mag_r[i] >> 1;
          end
          k_r <= k_r + 5'd1;
        end
        cnt_r <= 5'd0;
      end
      N_SQ: begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r != 5'd0) begin
          acc_r <= acc_r + mul_p;
        end
        if (cnt_r == 5'd3) begin
          root_r <= 64'd0;
          bit_r  <= 64'h4000_0000_0000_0000;
        end
      end
      N_SQRT: begin
        if (take) begin
          acc_r <= acc_r - trial;
        end
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        if (bit_r[0]) begin
          len_r <= root_nxt[31:0];
          idx_r <= 2'd0;
          cnt_r <= 5'd0;
          rem_r <= {1'b0, mag_r[0][31:0]};
          q_r   <= 17'd0;
          if (lonly_r || (root_nxt == 64'd0)) begin
            for (int i = 0; i < 3; i++) begin
              unit_r[i] <= '0;
            end
          end
        end
      end
      N_DIV: begin
        if (cnt_r == 5'd16) begin
          unit_r[idx_r] <= neg_r[idx_r] ? -$signed({1'b0, q_nxt})
                                         : $signed({1'b0, q_nxt});
          idx_r <= idx_r + 2'd1;
          cnt_r <= 5'd0;
          rem_r <= {1'b0, mag_nx[31:0]};
          q_r   <= 17'd0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/object_seek_transform_step_unit.sv
// Serves set flag, move along an axis, look at and seek requests. Each
// normalization goes through the shared root and divide unit, for a
// length alone or with the unit vector. One transaction is in work at a time.
// Reset (rst_n low, synchronous) restores position, axes, flag and registers.
`timescale 1ns / 1ps

module object_seek_transform_step_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [30:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_x, target_y, target_z, time_delta, moving_value, zero fill
  input  logic [119:0] in_tdata,
  // req_type
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x/y/z, look_x/y/z, right_x/y/z, moving, zero fill
  output logic [295:0] out_tdata
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_MV_WAIT  = 5'd2;
  localparam logic [4:0] S_STEP     = 5'd3;
  localparam logic [4:0] S_STEP_W   = 5'd4;
  localparam logic [4:0] S_DISP     = 5'd5;
  localparam logic [4:0] S_DISP_W   = 5'd6;
  localparam logic [4:0] S_SK_WAIT  = 5'd7;
  localparam logic [4:0] S_AIM_L    = 5'd8;
  localparam logic [4:0] S_AIM_LW   = 5'd9;
  localparam logic [4:0] S_AIM_RW   = 5'd10;
  localparam logic [4:0] S_AIM_DW   = 5'd11;
  localparam logic [4:0] S_SCL_L    = 5'd12;
  localparam logic [4:0] S_SCL_LW   = 5'd13;
  localparam logic [4:0] S_AIM_C    = 5'd14;
  localparam logic [4:0] S_AIM_CW   = 5'd15;
  localparam logic [4:0] S_SCL_R    = 5'd16;
  localparam logic [4:0] S_SCL_RW   = 5'd17;
  localparam logic [4:0] S_FIN      = 5'd18;

  logic [4:0]   st_r, st_nxt;
  logic [2:0]   req_r;
  ostu_pkg::q_t tgt_r [3];
  logic [15:0]  td_r;
  logic         mv_r;
  logic [30:0]  speed_r, arrive_r;
  ostu_pkg::q_t pos_r [3];
  ostu_pkg::q_t look_r [3];
  ostu_pkg::q_t right_r [3];
  logic         moving_r;
  logic [30:0]  step_r;
  logic [31:0]  sz_r, sx_r;
  logic [1:0]   idx_r;
  logic         out_valid_r;
  logic [295:0] out_data_r;
  logic [63:0]  prod_r;

  logic [31:0]          mul_a, mul_b;
  ostu_pkg::mul_req_t   norm_mul;
  ostu_pkg::norm_stat_t norm_stat;
  ostu_pkg::unit_t      norm_unit [3];
  logic [31:0]          norm_len;
  logic [4:0]           norm_shift;
  logic                 norm_start, norm_lonly;
  ostu_pkg::wide_t      norm_vec [3];
  ostu_pkg::wide_t      diff_v [3], cross_v [3];
  // Axis registers widened for the normalizer input.
  ostu_pkg::wide_t      look_w [3], right_w [3];

  logic            accept, seek_req, gated_run, backward, far;
  ostu_pkg::unit_t u_sel;
  logic [16:0]     u_abs;
  logic            d_neg;
  logic signed [33:0] pos_sum, scl_val;
  ostu_pkg::q_t    pos_new, scl_sat;

  function automatic ostu_pkg::q_t sat34(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic ostu_pkg::wide_t sx49(input ostu_pkg::q_t v);
    return ostu_pkg::wide_t'(v);
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE) && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign seek_req  = (req_r == ostu_pkg::REQ_SEEK_GATED) || (req_r == ostu_pkg::REQ_SEEK);
  assign gated_run = (req_r != ostu_pkg::REQ_SEEK_GATED) || moving_r;
  assign backward  = (req_r == ostu_pkg::REQ_BACK) || (req_r == ostu_pkg::REQ_LEFT);
  // A prescaled distance means the halved length already exceeds 2^30, so
  // the true distance is beyond any 31-bit arrival distance.
  assign far = (norm_shift != 5'd0) || (norm_len >= {1'b0, arrive_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_v[i] = ostu_pkg::wide_t'(tgt_r[i]) - ostu_pkg::wide_t'(pos_r[i]);
    end
    // Up axis is fixed at (0, one, 0), so up x look reduces to two terms.
    cross_v[0] = ostu_pkg::wide_t'({look_r[2][31], look_r[2], 16'h0000});
    cross_v[1] = '0;
    cross_v[2] = -ostu_pkg::wide_t'({look_r[0][31], look_r[0], 16'h0000});
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      look_w[i]  = sx49(look_r[i]);
      right_w[i] = sx49(right_r[i]);
    end
  end

  always_comb begin
    norm_vec   = diff_v;
    norm_start = 1'b0;
    norm_lonly = 1'b0;
    case (st_r)
      S_DISPATCH: begin
        if (req_r inside {ostu_pkg::REQ_FWD, ostu_pkg::REQ_BACK}) begin
          norm_vec   = look_w;
          norm_start = 1'b1;
        end else if (req_r inside {ostu_pkg::REQ_LEFT, ostu_pkg::REQ_RIGHT}) begin
          norm_vec   = right_w;
          norm_start = 1'b1;
        end else if (seek_req) begin
          norm_start = gated_run;
        end
      end
      S_AIM_L: begin
        norm_vec   = look_w;
        norm_start = 1'b1;
        norm_lonly = 1'b1;
      end
      S_AIM_LW: begin
        norm_vec   = right_w;
        norm_start = norm_stat.done;
        norm_lonly = 1'b1;
      end
      S_AIM_RW: norm_start = norm_stat.done;
      S_AIM_C: begin
        norm_vec   = cross_v;
        norm_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (idx_r)
      2'd0:    u_sel = norm_unit[0];
      2'd1:    u_sel = norm_unit[1];
      default: u_sel = norm_unit[2];
    endcase
  end

  assign u_abs = u_sel[17] ? 17'(-u_sel) : u_sel[16:0];
  assign d_neg = u_sel[17] ^ backward;

  always_comb begin
    if (!norm_stat.rdy) begin
      mul_a = norm_mul.a;
      mul_b = norm_mul.b;
    end else begin
      case (st_r)
        S_STEP: begin
          mul_a = {1'b0, speed_r};
          mul_b = {16'h0000, td_r};
        end
        S_DISP: begin
          mul_a = {15'h0000, u_abs};
          mul_b = {1'b0, step_r};
        end
        S_SCL_L: begin
          mul_a = {15'h0000, u_abs};
          mul_b = sz_r;
        end
        S_SCL_R: begin
          mul_a = {15'h0000, u_abs};
          mul_b = sx_r;
        end
        default: begin
          mul_a = 32'd0;
          mul_b = 32'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    pos_sum = 34'(pos_r[idx_r]) +
              (d_neg ? -$signed({2'b00, prod_r[47:16]}) : $signed({2'b00, prod_r[47:16]}));
    pos_new = sat34(pos_sum);
    scl_val = u_sel[17] ? -$signed({1'b0, prod_r[48:16]}) : $signed({1'b0, prod_r[48:16]});
    scl_sat = sat34(scl_val);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:     if (accept) st_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (req_r == ostu_pkg::REQ_SET_FLAG) begin
          st_nxt = S_FIN;
        end else if (req_r == ostu_pkg::REQ_LOOK_AT) begin
          st_nxt = S_AIM_L;
        end else if (seek_req) begin
          st_nxt = gated_run ? S_SK_WAIT : S_FIN;
        end else begin
          st_nxt = S_MV_WAIT;
        end
      end
      S_MV_WAIT: if (norm_stat.done) st_nxt = S_STEP;
      S_SK_WAIT: if (norm_stat.done) st_nxt = far ? S_STEP : S_AIM_L;
      S_STEP:    st_nxt = S_STEP_W;
      S_STEP_W:  st_nxt = S_DISP;
      S_DISP:    st_nxt = S_DISP_W;
      S_DISP_W: begin
        if (idx_r != 2'd2) begin
          st_nxt = S_DISP;
        end else begin
          st_nxt = seek_req ? S_AIM_L : S_FIN;
        end
      end
      S_AIM_L:   st_nxt = S_AIM_LW;
      S_AIM_LW:  if (norm_stat.done) st_nxt = S_AIM_RW;
      S_AIM_RW:  if (norm_stat.done) st_nxt = S_AIM_DW;
      S_AIM_DW:  if (norm_stat.done) st_nxt = S_SCL_L;
      S_SCL_L:   st_nxt = S_SCL_LW;
      S_SCL_LW:  st_nxt = (idx_r == 2'd2) ? S_AIM_C : S_SCL_L;
      S_AIM_C:   st_nxt = S_AIM_CW;
      S_AIM_CW:  if (norm_stat.done) st_nxt = S_SCL_R;
      S_SCL_R:   st_nxt = S_SCL_RW;
      S_SCL_RW:  st_nxt = (idx_r == 2'd2) ? S_FIN : S_SCL_R;
      S_FIN:     if (!out_valid_r || out_tready) st_nxt = S_IDLE;
      default:   st_nxt = S_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      moving_r    <= 1'b0;
      speed_r     <= ostu_pkg::SPEED_RESET;
      arrive_r    <= ostu_pkg::ARRIVE_RESET;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
      end
      right_r[0] <= ostu_pkg::Q_ONE;
      right_r[1] <= '0;
      right_r[2] <= '0;
      look_r[0]  <= '0;
      look_r[1]  <= '0;
      look_r[2]  <= ostu_pkg::Q_ONE;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          ostu_pkg::CFG_SPEED:  speed_r  <= cfg_wdata;
          ostu_pkg::CFG_ARRIVE: arrive_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((st_r == S_FIN) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_DISPATCH: begin
          if (req_r == ostu_pkg::REQ_SET_FLAG) begin
            moving_r <= mv_r;
          end
        end
        S_SK_WAIT: begin
          if (norm_stat.done && !far && (req_r == ostu_pkg::REQ_SEEK_GATED)) begin
            moving_r <= 1'b0;
          end
        end
        S_DISP_W: pos_r[idx_r]   <= pos_new;
        S_SCL_LW: look_r[idx_r]  <= scl_sat;
        S_SCL_RW: right_r[idx_r] <= scl_sat;
        default: ;
      endcase
    end
  end

  // Transaction payload and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_tuser;
      tgt_r[0] <= in_tdata[31:0];
      tgt_r[1] <= in_tdata[63:32];
      tgt_r[2] <= in_tdata[95:64];
      td_r     <= in_tdata[111:96];
      mv_r     <= in_tdata[112];
    end
    case (st_r)
      S_STEP_W: begin
        step_r <= prod_r[46:16];
        idx_r  <= 2'd0;
      end
      S_DISP_W, S_SCL_LW, S_SCL_RW: idx_r <= idx_r + 2'd1;
      S_AIM_LW: if (norm_stat.done) sz_r <= norm_len;
      S_AIM_RW: if (norm_stat.done) sx_r <= norm_len;
      S_AIM_DW, S_AIM_CW: idx_r <= 2'd0;
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {7'd0, moving_r, right_r[2], right_r[1], right_r[0],
                         look_r[2], look_r[1], look_r[0], pos_r[2], pos_r[1], pos_r[0]};
        end
      end
      default: ;
    endcase
  end

  ostu_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (norm_start),
    .len_only (norm_lonly),
    .vec      (norm_vec),
    .mul_p    (prod_r),
    .mul_req  (norm_mul),
    .stat     (norm_stat),
    .unit     (norm_unit),
    .len      (norm_len),
    .shift    (norm_shift)
  );

`ifndef NO_ASSERTIONS
  // The normalizer is only started when it can take a new vector.
  a_norm_start: assert property (@(posedge clk) disable iff (!rst_n)
    norm_start |-> norm_stat.rdy)
    else $error("normalizer started while busy");

  // One transaction at a time: ready drops right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second transaction accepted while busy");

  // Only a flag write or a gated seek changes the moving flag.
  a_flag_src: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(moving_r) |-> ($past(req_r) == ostu_pkg::REQ_SET_FLAG ||
                            $past(req_r) == ostu_pkg::REQ_SEEK_GATED))
    else $error("moving flag changed by wrong request");
`endif

endmodule
